// ----- design/sbbf_pkg.sv -----
`default_nettype none

package sbbf_pkg;

    localparam int SBBF_LOG2_MAX_BLOCKS = 12;
    localparam int SBBF_WORDS_PER_BLOCK = 8;
    localparam int SBBF_WORD_BITS       = 32;
    localparam int SBBF_SALT_SHIFT      = 27;
    localparam int SBBF_BITPOS_BITS     = 5;
    localparam int SBBF_QUEUE_DEPTH     = 2;
    localparam int SBBF_CFG_BITS        = 4;
    localparam logic [SBBF_CFG_BITS-1:0] SBBF_CFG_RESET = 4'd12;

    // word 0 salt in the lowest bits
    localparam logic [SBBF_WORDS_PER_BLOCK-1:0][SBBF_WORD_BITS-1:0] SBBF_SALT = {
        32'h5c6bfb31, 32'h9efc4947, 32'h2df1424b, 32'h705495c7,
        32'ha2b7289d, 32'h8824ad5b, 32'h44974d91, 32'h47b6137b
    };

    typedef enum logic [1:0] {
        OP_INSERT_HASH = 2'd0,
        OP_QUERY_HASH  = 2'd1,
        OP_INSERT_KEY  = 2'd2,
        OP_QUERY_KEY   = 2'd3
    } t_op;

    typedef struct packed {
        logic                                                   query;
        logic [SBBF_WORDS_PER_BLOCK-1:0][SBBF_BITPOS_BITS-1:0] bitpos;
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_FOLD,
        F_SALT,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ
    } t_back_state;

endpackage

`default_nettype wire

// ----- design/sbbf_queue.sv -----
`default_nettype none

module sbbf_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int Depth  = sbbf_pkg::SBBF_QUEUE_DEPTH;
    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    logic [WIDTH-1:0]  r_entry [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CountW-1:0] r_count;
    logic [PtrW-1:0]   n_wr_ptr;
    logic [PtrW-1:0]   n_rd_ptr;
    logic [CountW-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CountW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/sbbf_front.sv -----
`default_nettype none

module sbbf_front #(
    parameter int LOG2_MAX_BLOCKS = sbbf_pkg::SBBF_LOG2_MAX_BLOCKS,
    parameter int ADDR_W          = (LOG2_MAX_BLOCKS > 0) ? LOG2_MAX_BLOCKS : 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_enable,
    input  wire logic [sbbf_pkg::SBBF_CFG_BITS-1:0] i_cfg_log2,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [1:0]                         i_operation,
    input  wire logic [63:0]                        i_key_low,
    input  wire logic [63:0]                        i_key_high,
    output logic                                    o_push,
    output sbbf_pkg::t_cmd                          o_cmd,
    output logic [ADDR_W-1:0]                       o_block,
    input  wire logic                               i_queue_full
);

    localparam int Words = sbbf_pkg::SBBF_WORDS_PER_BLOCK;
    localparam logic [4:0] LgMax = 5'(LOG2_MAX_BLOCKS);

    sbbf_pkg::t_front_state r_state;
    sbbf_pkg::t_front_state n_state;

    sbbf_pkg::t_op r_op;
    logic [63:0]   r_key_low;
    logic [63:0]   r_key_high;
    logic [63:0]   r_p00;
    logic [63:0]   r_p01;
    logic [63:0]   r_p10;
    logic [63:0]   r_p11;
    logic [63:0]   r_hash;
    logic          r_query;
    logic [ADDR_W-1:0] r_block;
    logic [Words-1:0][sbbf_pkg::SBBF_BITPOS_BITS-1:0] r_bitpos;

    logic          keyed;
    logic [33:0]   mid;
    logic [63:0]   hi;
    logic [63:0]   n_hash;
    logic [4:0]    cfg_ext;
    logic [4:0]    lg_eff;
    logic [31:0]   block_mask;
    logic [31:0]   block_sel;
    logic [31:0]   salt_prod [Words];
    logic [Words-1:0][sbbf_pkg::SBBF_BITPOS_BITS-1:0] n_bitpos;
    logic          accept;

    assign keyed = (r_op == sbbf_pkg::OP_INSERT_KEY) || (r_op == sbbf_pkg::OP_QUERY_KEY);

    // key operations fold the 128-bit product, low half xor high half; hash operations pass key_low
    always_comb begin
        mid = {2'b00, r_p00[63:32]} + {2'b00, r_p01[31:0]} + {2'b00, r_p10[31:0]};
        hi  = r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]} + {62'd0, mid[33:32]};
        n_hash = keyed ? ({mid[31:0], r_p00[31:0]} ^ hi) : r_key_low;
    end

    always_comb begin
        cfg_ext    = {1'b0, i_cfg_log2};
        lg_eff     = (cfg_ext > LgMax) ? LgMax : cfg_ext;
        block_mask = (32'd1 << lg_eff) - 32'd1;
        block_sel  = r_hash[63:32] & block_mask;
        for (int w = 0; w < Words; w++) begin
            salt_prod[w] = r_hash[31:0] * sbbf_pkg::SBBF_SALT[w];
            n_bitpos[w]  = salt_prod[w][31:sbbf_pkg::SBBF_SALT_SHIFT];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbbf_pkg::F_IDLE: begin
                if (i_valid && i_enable) begin
                    n_state = sbbf_pkg::F_MUL;
                end
            end
            sbbf_pkg::F_MUL:  n_state = sbbf_pkg::F_FOLD;
            sbbf_pkg::F_FOLD: n_state = sbbf_pkg::F_SALT;
            sbbf_pkg::F_SALT: n_state = sbbf_pkg::F_PUSH;
            sbbf_pkg::F_PUSH: begin
                if (!i_queue_full) begin
                    n_state = sbbf_pkg::F_IDLE;
                end
            end
            default: n_state = sbbf_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            sbbf_pkg::F_IDLE: o_ready = i_enable;
            sbbf_pkg::F_PUSH: o_push  = !i_queue_full;
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
    end

    assign accept       = o_ready && i_valid;
    assign o_cmd.query  = r_query;
    assign o_cmd.bitpos = r_bitpos;
    assign o_block      = r_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbbf_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= sbbf_pkg::t_op'(i_operation);
            r_key_low  <= i_key_low;
            r_key_high <= i_key_high;
        end
        if (r_state == sbbf_pkg::F_MUL) begin
            r_p00 <= r_key_low[31:0]  * r_key_high[31:0];
            r_p01 <= r_key_low[31:0]  * r_key_high[63:32];
            r_p10 <= r_key_low[63:32] * r_key_high[31:0];
            r_p11 <= r_key_low[63:32] * r_key_high[63:32];
        end
        if (r_state == sbbf_pkg::F_FOLD) begin
            r_hash  <= n_hash;
            r_query <= (r_op == sbbf_pkg::OP_QUERY_HASH) || (r_op == sbbf_pkg::OP_QUERY_KEY);
        end
        if (r_state == sbbf_pkg::F_SALT) begin
            r_bitpos <= n_bitpos;
            r_block  <= block_sel[ADDR_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/sbbf_back.sv -----
`default_nettype none

module sbbf_back #(
    parameter int LOG2_MAX_BLOCKS = sbbf_pkg::SBBF_LOG2_MAX_BLOCKS,
    parameter int ADDR_W          = (LOG2_MAX_BLOCKS > 0) ? LOG2_MAX_BLOCKS : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    output logic                   o_clear_done,
    input  wire logic              i_q_valid,
    input  wire sbbf_pkg::t_cmd    i_q_cmd,
    input  wire logic [ADDR_W-1:0] i_q_block,
    output logic                   o_q_pop,
    output logic                   o_valid,
    output logic                   o_found,
    input  wire logic              i_ready
);

    localparam int Words  = sbbf_pkg::SBBF_WORDS_PER_BLOCK;
    localparam int WordW  = sbbf_pkg::SBBF_WORD_BITS;
    localparam int RowW   = Words * WordW;
    localparam int Rows   = 2 ** ADDR_W;

    sbbf_pkg::t_back_state r_state;
    sbbf_pkg::t_back_state n_state;

    logic [RowW-1:0]   r_mem [Rows];
    logic [RowW-1:0]   r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    sbbf_pkg::t_cmd    r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic              r_out_valid;
    logic              r_out_found;
    logic              n_out_valid;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [RowW-1:0]   mem_wdata;
    logic              out_load;
    logic [RowW-1:0]   row_mask;
    logic              all_set;

    always_comb begin
        all_set = 1'b1;
        for (int w = 0; w < Words; w++) begin
            row_mask[w*WordW +: WordW] = WordW'(1) << r_cmd.bitpos[w];
            if ((r_rd_data[w*WordW +: WordW] & row_mask[w*WordW +: WordW]) == '0) begin
                all_set = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbbf_pkg::B_CLEAR: begin
                if (r_clr_addr == ADDR_W'(Rows - 1)) begin
                    n_state = sbbf_pkg::B_IDLE;
                end
            end
            sbbf_pkg::B_IDLE: begin
                if (i_q_valid && (!r_out_valid || i_ready)) begin
                    n_state = sbbf_pkg::B_READ;
                end
            end
            sbbf_pkg::B_READ: n_state = sbbf_pkg::B_IDLE;
            default:          n_state = sbbf_pkg::B_CLEAR;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rd_data | row_mask;
        out_load  = 1'b0;
        case (r_state)
            sbbf_pkg::B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            sbbf_pkg::B_IDLE: o_q_pop = i_q_valid && (!r_out_valid || i_ready);
            sbbf_pkg::B_READ: begin
                mem_we   = !r_cmd.query;
                out_load = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_clear_done = (r_state != sbbf_pkg::B_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbbf_pkg::B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == sbbf_pkg::B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd  <= i_q_cmd;
            r_addr <= i_q_block;
        end
        if (out_load) begin
            r_out_found <= r_cmd.query && all_set;
        end
    end

    // block store, one 256-bit row per block
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[i_q_block];
    end

endmodule

`default_nettype wire

// ----- design/split_block_bloom_filter.sv -----
// Split block Bloom filter, 256-bit blocks of eight 32-bit words.
// Input stream s_axis carries one insert or query item per handshake; tdata
// holds operation, key_low and key_high. Output stream m_axis returns one item
// per input item, in order, with found in bit 0 (always 0 for an insert).
// i_cfg_wr_en/i_cfg_wr_data set block_count_log2 (reset 12, values above
// LOG2_MAX_BLOCKS act as LOG2_MAX_BLOCKS); write it only while idle.
// The front end takes one item at a time: register, four 32x32 partial
// products, fold, eight salt products, then a push into a 2-entry queue.
// The back end does a read-modify-write of one block row in the block
// store per item, and pops the next item only once that write is done.
// After reset the store is cleared one row a cycle, all 2**LOG2_MAX_BLOCKS
// rows (4096 by default), with s_axis_tready low the whole time.
// When m_axis_tready is low the result stays in the output register; the
// queue then fills and s_axis_tready drops once the front end cannot push.
`default_nettype none

module split_block_bloom_filter #(
    parameter int LOG2_MAX_BLOCKS = sbbf_pkg::SBBF_LOG2_MAX_BLOCKS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [sbbf_pkg::SBBF_CFG_BITS-1:0] i_cfg_wr_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [135:0]                       s_axis_tdata,  // operation, key_low, key_high
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [7:0]                              m_axis_tdata   // found
);

    localparam int AddrW = (LOG2_MAX_BLOCKS > 0) ? LOG2_MAX_BLOCKS : 1;
    localparam int CmdW  = $bits(sbbf_pkg::t_cmd);
    localparam int QW    = CmdW + AddrW;

    logic [sbbf_pkg::SBBF_CFG_BITS-1:0] r_block_count_log2;

    logic              clear_done;
    logic              push;
    sbbf_pkg::t_cmd    push_cmd;
    logic [AddrW-1:0]  push_block;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [QW-1:0]     q_data;
    sbbf_pkg::t_cmd    q_cmd;
    logic [AddrW-1:0]  q_block;
    logic              found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count_log2 <= sbbf_pkg::SBBF_CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_block_count_log2 <= i_cfg_wr_data;
        end
    end

    sbbf_front #(
        .LOG2_MAX_BLOCKS (LOG2_MAX_BLOCKS),
        .ADDR_W          (AddrW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (clear_done),
        .i_cfg_log2   (r_block_count_log2),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_operation  (s_axis_tdata[1:0]),
        .i_key_low    (s_axis_tdata[65:2]),
        .i_key_high   (s_axis_tdata[129:66]),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_block      (push_block),
        .i_queue_full (q_full)
    );

    sbbf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_block, push_cmd}),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    assign q_cmd   = sbbf_pkg::t_cmd'(q_data[CmdW-1:0]);
    assign q_block = q_data[QW-1:CmdW];

    sbbf_back #(
        .LOG2_MAX_BLOCKS (LOG2_MAX_BLOCKS),
        .ADDR_W          (AddrW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_clear_done (clear_done),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .i_q_block    (q_block),
        .o_q_pop      (q_pop),
        .o_valid      (m_axis_tvalid),
        .o_found      (found),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, found};

endmodule

`default_nettype wire
